// ----- hdl/antialiased_line_rasterizer_assert.svh -----
// Assertion macros shared by the line rasterizer RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ANTIALIASED_LINE_RASTERIZER_ASSERT_SVH
`define ANTIALIASED_LINE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ALR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ALR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/alr_pkg.sv -----
// Shared types, constants and arithmetic helpers for the line rasterizer.
// No dependencies; imported by every module of the block but alr_div.
`timescale 1ns / 1ps
`default_nettype none

package alr_pkg;

  localparam int ALR_COORD_BITS = 12;
  localparam int ALR_FIFO_DEPTH = 4;

  // Error and intensity scales.
  localparam int ALR_FULL_SCALE = 100;
  localparam int ALR_RECIP_NUM  = 10000;
  localparam logic [7:0] ALR_MAX_LEVEL = 8'd255;
  // err*255/100 computed as (err*1336965) >> 19, exact for err below 100.
  localparam logic [20:0] ALR_E_RECIP = 21'd1336965;
  localparam int ALR_E_SHIFT = 19;

  // Queue entry: kind, y-major flag, error increment, minor direction,
  // then three coordinates.
  localparam int ALR_ENTRY_FIXED_W = 11;
  localparam int ALR_INC_W = 7;

  // Configuration register map.
  localparam int ALR_PADDR_W = 4;
  localparam logic [1:0] ALR_REG_RED   = 2'd0;
  localparam logic [1:0] ALR_REG_GREEN = 2'd1;
  localparam logic [1:0] ALR_REG_BLUE  = 2'd2;
  localparam logic [7:0] ALR_COLOUR_RESET = 8'd100;

  // Input operation codes.
  localparam logic ALR_OP_LOAD = 1'b0;
  localparam logic ALR_OP_STEP = 1'b1;

  // Minor step direction codes (two's complement).
  localparam logic [1:0] ALR_DIR_NONE = 2'b00;
  localparam logic [1:0] ALR_DIR_POS  = 2'b01;
  localparam logic [1:0] ALR_DIR_NEG  = 2'b11;

  typedef enum logic {
    ALR_KIND_LOAD = 1'b0,
    ALR_KIND_STEP = 1'b1
  } alr_kind_e;

  typedef struct packed {
    logic full;
    logic empty;
  } alr_fifo_status_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } alr_colour_t;

  // Weight of the neighbour pixel for an error in hundredths.
  function automatic logic [7:0] alr_err_to_e(input logic [6:0] err);
    logic [27:0] prod;
    prod = 28'(err) * 28'(ALR_E_RECIP);
    return prod[ALR_E_SHIFT+7:ALR_E_SHIFT];
  endfunction

  // w*c/255 with the add-and-shift form of division by 255.
  function automatic logic [7:0] alr_scale(input logic [7:0] w, input logic [7:0] c);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = w * c;
    sum  = {1'b0, prod} + 17'(prod[15:8]) + 17'd1;
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/alr_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Uses no package items; instantiated by the line setup front end.
`timescale 1ns / 1ps
`default_nettype none

module alr_div #(
  parameter int WIDTH = 19
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] num_i,
  input  logic [WIDTH-1:0] den_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quot_o
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [WIDTH-1:0] nq_q;
  logic [WIDTH-1:0] rem_q;
  logic [WIDTH-1:0] den_q;

  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   trial;
  logic             fits;
  logic [WIDTH-1:0] rem_d;

  always_comb begin
    rem_sh = {rem_q, nq_q[WIDTH-1]};
    trial  = rem_sh - {1'b0, den_q};
    fits   = !trial[WIDTH];
    rem_d  = fits ? trial[WIDTH-1:0] : rem_sh[WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      nq_q   <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(WIDTH - 1);
        nq_q   <= num_i;
        rem_q  <= '0;
        den_q  <= den_i;
      end else if (busy_q) begin
        rem_q <= rem_d;
        nq_q  <= {nq_q[WIDTH-2:0], fits};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = nq_q;

endmodule

`default_nettype wire

// ----- hdl/alr_front.sv -----
// Front end: accepts input transfers, sets up loaded lines and queues work.
// Depends on alr_pkg and alr_div.
`timescale 1ns / 1ps
`default_nettype none

module alr_front #(
  parameter int COORD_BITS = alr_pkg::ALR_COORD_BITS
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             in_valid_i,
  output logic                                             in_ready_o,
  input  logic                                             op_i,
  input  logic signed [COORD_BITS-1:0]                     start_x_i,
  input  logic signed [COORD_BITS-1:0]                     start_y_i,
  input  logic signed [COORD_BITS-1:0]                     end_x_i,
  input  logic signed [COORD_BITS-1:0]                     end_y_i,
  input  alr_pkg::alr_fifo_status_t                        fifo_status_i,
  output logic                                             push_o,
  output logic [alr_pkg::ALR_ENTRY_FIXED_W+3*COORD_BITS-1:0] entry_o
);

  import alr_pkg::*;

  localparam int ENTRY_W = ALR_ENTRY_FIXED_W + 3 * COORD_BITS;
  localparam int NUM_W   = COORD_BITS + 7;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SETUP,
    F_DIV1,
    F_WAIT1,
    F_DIV2,
    F_WAIT2,
    F_PUSH
  } front_state_e;

  front_state_e state_q;

  logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [COORD_BITS-1:0] maj_start_q, maj_end_q, min_start_q;
  logic [COORD_BITS-1:0]        dx_q, dy_q;
  logic                         ymaj_q;
  logic [1:0]                   dir_q;
  logic [ALR_INC_W-1:0]         inc_q;
  logic [NUM_W-1:0]             slope_q;

  logic                         accept;
  logic signed [COORD_BITS:0]   diff_x, diff_y, neg_x, neg_y;
  logic [COORD_BITS-1:0]        adx, ady;
  logic                         ymaj_w, swap_w, up_w, down_w;
  logic                         gt_x, lt_x, gt_y, lt_y;
  logic signed [COORD_BITS-1:0] maj_start_w, maj_end_w, min_start_w;
  logic [1:0]                   dir_w;
  logic                         flat_w;

  logic                         div_start, div_done;
  logic [NUM_W-1:0]             div_num, div_den, div_quot, dy100;

  assign in_ready_o = (state_q == F_IDLE) && !fifo_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // Line classification from the stored endpoints.
  always_comb begin
    diff_x = $signed({bx_q[COORD_BITS-1], bx_q}) - $signed({ax_q[COORD_BITS-1], ax_q});
    diff_y = $signed({by_q[COORD_BITS-1], by_q}) - $signed({ay_q[COORD_BITS-1], ay_q});
    neg_x  = -diff_x;
    neg_y  = -diff_y;
    adx    = diff_x[COORD_BITS] ? neg_x[COORD_BITS-1:0] : diff_x[COORD_BITS-1:0];
    ady    = diff_y[COORD_BITS] ? neg_y[COORD_BITS-1:0] : diff_y[COORD_BITS-1:0];
    ymaj_w = (ady >= adx);
    gt_x   = bx_q > ax_q;
    lt_x   = bx_q < ax_q;
    gt_y   = by_q > ay_q;
    lt_y   = by_q < ay_q;
    if (ymaj_w) begin
      swap_w      = lt_y;
      maj_start_w = swap_w ? by_q : ay_q;
      maj_end_w   = swap_w ? ay_q : by_q;
      min_start_w = swap_w ? bx_q : ax_q;
      up_w        = swap_w ? lt_x : gt_x;
      down_w      = swap_w ? gt_x : lt_x;
    end else begin
      swap_w      = lt_x;
      maj_start_w = swap_w ? bx_q : ax_q;
      maj_end_w   = swap_w ? ax_q : bx_q;
      min_start_w = swap_w ? by_q : ay_q;
      up_w        = swap_w ? lt_y : gt_y;
      down_w      = swap_w ? gt_y : lt_y;
    end
    if (up_w) begin
      dir_w = ALR_DIR_POS;
    end else if (down_w) begin
      dir_w = ALR_DIR_NEG;
    end else begin
      dir_w = ALR_DIR_NONE;
    end
  end

  // A vertical or single-point line has slope 100 by definition, so its increment is full scale.
  assign flat_w    = ymaj_q && (dx_q == '0);
  assign dy100     = (NUM_W'(dy_q) << 6) + (NUM_W'(dy_q) << 5) + (NUM_W'(dy_q) << 2);
  assign div_start = ((state_q == F_DIV1) && !flat_w) || (state_q == F_DIV2);
  assign div_num   = (state_q == F_DIV2) ? NUM_W'(ALR_RECIP_NUM) : dy100;
  assign div_den   = (state_q == F_DIV2) ? slope_q : NUM_W'(dx_q);

  alr_div #(
    .WIDTH(NUM_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    push_o  = 1'b0;
    entry_o = {ALR_KIND_LOAD, ymaj_q, inc_q, dir_q, maj_start_q, maj_end_q, min_start_q};
    if (state_q == F_IDLE) begin
      push_o  = accept && (op_i == ALR_OP_STEP);
      entry_o = {ALR_KIND_STEP, (ENTRY_W - 1)'(0)};
    end else if (state_q == F_PUSH) begin
      push_o = !fifo_status_i.full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      ax_q        <= '0;
      ay_q        <= '0;
      bx_q        <= '0;
      by_q        <= '0;
      maj_start_q <= '0;
      maj_end_q   <= '0;
      min_start_q <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      ymaj_q      <= 1'b0;
      dir_q       <= ALR_DIR_NONE;
      inc_q       <= '0;
      slope_q     <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (accept && (op_i == ALR_OP_LOAD)) begin
            ax_q    <= start_x_i;
            ay_q    <= start_y_i;
            bx_q    <= end_x_i;
            by_q    <= end_y_i;
            state_q <= F_SETUP;
          end
        end
        F_SETUP: begin
          dx_q        <= adx;
          dy_q        <= ady;
          ymaj_q      <= ymaj_w;
          maj_start_q <= maj_start_w;
          maj_end_q   <= maj_end_w;
          min_start_q <= min_start_w;
          dir_q       <= dir_w;
          state_q     <= F_DIV1;
        end
        F_DIV1: begin
          if (flat_w) begin
            inc_q   <= ALR_INC_W'(ALR_FULL_SCALE);
            state_q <= F_PUSH;
          end else begin
            state_q <= F_WAIT1;
          end
        end
        F_WAIT1: begin
          if (div_done) begin
            if (ymaj_q) begin
              slope_q <= div_quot;
              state_q <= F_DIV2;
            end else begin
              inc_q   <= div_quot[ALR_INC_W-1:0];
              state_q <= F_PUSH;
            end
          end
        end
        F_DIV2: begin
          state_q <= F_WAIT2;
        end
        F_WAIT2: begin
          if (div_done) begin
            inc_q   <= div_quot[ALR_INC_W-1:0];
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!fifo_status_i.full) begin
            state_q <= F_IDLE;
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/alr_fifo.sv -----
// Short command queue between the setup front end and the pixel back end.
// Depends on alr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "antialiased_line_rasterizer_assert.svh"

module alr_fifo #(
  parameter int WIDTH = 47,
  parameter int DEPTH = alr_pkg::ALR_FIFO_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [WIDTH-1:0]          data_i,
  input  logic                      pop_i,
  output logic [WIDTH-1:0]          data_o,
  output alr_pkg::alr_fifo_status_t status_o
);

  import alr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign data_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  `ALR_ASSERT_IMPLIES(a_no_push_full, clk_i, rst_ni, push_i, !status_o.full, "push into full queue")
  `ALR_ASSERT_IMPLIES(a_no_pop_empty, clk_i, rst_ni, pop_i, !status_o.empty, "pop from empty queue")
  `ALR_ASSERT_NEXT(a_fill_tracks, clk_i, rst_ni, push_i && !pop_i,
                   cnt_q == $past(cnt_q) + CNT_W'(1), "queue fill count lost a push")

endmodule

`default_nettype wire

// ----- hdl/alr_back.sv -----
// Back end: executes queued line loads and steps, emitting pixel pairs.
// Depends on alr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "antialiased_line_rasterizer_assert.svh"

module alr_back #(
  parameter int COORD_BITS = alr_pkg::ALR_COORD_BITS
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  alr_pkg::alr_fifo_status_t                          fifo_status_i,
  input  logic [alr_pkg::ALR_ENTRY_FIXED_W+3*COORD_BITS-1:0] entry_i,
  output logic                                               pop_o,
  input  alr_pkg::alr_colour_t                               colour_i,
  output logic                                               out_valid_o,
  input  logic                                               out_ready_i,
  output logic [COORD_BITS-1:0]                              pix_x_o,
  output logic [COORD_BITS-1:0]                              pix_y_o,
  output logic [7:0]                                         red_o,
  output logic [7:0]                                         green_o,
  output logic [7:0]                                         blue_o,
  output logic                                               is_neighbour_o,
  output logic                                               last_o
);

  import alr_pkg::*;

  localparam int ENTRY_W = ALR_ENTRY_FIXED_W + 3 * COORD_BITS;
  localparam int DIR_LSB = 3 * COORD_BITS;
  localparam int INC_LSB = DIR_LSB + 2;
  localparam int YMJ_BIT = INC_LSB + ALR_INC_W;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MAIN,
    B_NEIGH
  } back_state_e;

  back_state_e state_q;

  logic signed [COORD_BITS-1:0] major_pos_q, major_end_q, minor_pos_q;
  logic [ALR_INC_W-1:0]         error_acc_q, error_inc_q;
  logic [1:0]                   minor_dir_q;
  logic                         y_major_q, active_q;
  logic [7:0]                   e_q;

  logic                         out_valid_q, is_nb_q, last_q;
  logic [COORD_BITS-1:0]        pix_x_q, pix_y_q;
  logic [7:0]                   red_q, green_q, blue_q;

  alr_kind_e                    kind_w;
  logic                         slot_free;
  logic [7:0]                   w_w;
  logic signed [COORD_BITS-1:0] minor_sel, px_w, py_w, dir_ext, minor_step;
  logic                         last_w;
  logic [ALR_INC_W:0]           acc_sum;
  logic                         carry_w;
  logic [ALR_INC_W:0]           acc_wrapped;

  assign kind_w    = alr_kind_e'(entry_i[ENTRY_W-1]);
  assign pop_o     = (state_q == B_IDLE) && !fifo_status_i.empty;
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    w_w        = (state_q == B_NEIGH) ? e_q : (ALR_MAX_LEVEL - e_q);
    minor_sel  = (state_q == B_NEIGH) ? (minor_pos_q + COORD_BITS'(1)) : minor_pos_q;
    px_w       = y_major_q ? minor_sel : major_pos_q;
    py_w       = y_major_q ? major_pos_q : minor_sel;
    last_w     = (major_pos_q >= major_end_q);
    acc_sum    = {1'b0, error_acc_q} + {1'b0, error_inc_q};
    carry_w    = (acc_sum >= (ALR_INC_W + 1)'(ALR_FULL_SCALE));
    acc_wrapped = acc_sum - (ALR_INC_W + 1)'(ALR_FULL_SCALE);
    dir_ext    = {{(COORD_BITS - 2){minor_dir_q[1]}}, minor_dir_q};
    minor_step = minor_pos_q + dir_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      major_pos_q <= '0;
      major_end_q <= '0;
      minor_pos_q <= '0;
      error_acc_q <= '0;
      error_inc_q <= '0;
      minor_dir_q <= ALR_DIR_NONE;
      y_major_q   <= 1'b0;
      active_q    <= 1'b0;
      e_q         <= '0;
      out_valid_q <= 1'b0;
      is_nb_q     <= 1'b0;
      last_q      <= 1'b0;
      pix_x_q     <= '0;
      pix_y_q     <= '0;
      red_q       <= '0;
      green_q     <= '0;
      blue_q      <= '0;
    end else begin
      // The neighbour weight is registered from the error; every step passes through
      // idle after the error changes, so it is current when used.
      e_q <= alr_err_to_e(error_acc_q);
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            if (kind_w == ALR_KIND_LOAD) begin
              minor_pos_q <= entry_i[COORD_BITS-1:0];
              major_end_q <= entry_i[2*COORD_BITS-1:COORD_BITS];
              major_pos_q <= entry_i[3*COORD_BITS-1:2*COORD_BITS];
              minor_dir_q <= entry_i[DIR_LSB+1:DIR_LSB];
              error_inc_q <= entry_i[INC_LSB+ALR_INC_W-1:INC_LSB];
              y_major_q   <= entry_i[YMJ_BIT];
              error_acc_q <= '0;
              active_q    <= 1'b1;
            end else if (active_q) begin
              state_q <= B_MAIN;
            end
          end
        end
        B_MAIN: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            pix_x_q     <= px_w;
            pix_y_q     <= py_w;
            red_q       <= alr_scale(w_w, colour_i.red);
            green_q     <= alr_scale(w_w, colour_i.green);
            blue_q      <= alr_scale(w_w, colour_i.blue);
            is_nb_q     <= 1'b0;
            last_q      <= 1'b0;
            state_q     <= B_NEIGH;
          end
        end
        B_NEIGH: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            pix_x_q     <= px_w;
            pix_y_q     <= py_w;
            red_q       <= alr_scale(w_w, colour_i.red);
            green_q     <= alr_scale(w_w, colour_i.green);
            blue_q      <= alr_scale(w_w, colour_i.blue);
            is_nb_q     <= 1'b1;
            last_q      <= last_w;
            if (carry_w) begin
              error_acc_q <= acc_wrapped[ALR_INC_W-1:0];
              minor_pos_q <= minor_step;
            end else begin
              error_acc_q <= acc_sum[ALR_INC_W-1:0];
            end
            if (last_w) begin
              active_q <= 1'b0;
            end else begin
              major_pos_q <= major_pos_q + COORD_BITS'(1);
            end
            state_q <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pix_x_o        = pix_x_q;
  assign pix_y_o        = pix_y_q;
  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;
  assign is_neighbour_o = is_nb_q;
  assign last_o         = last_q;

  `ALR_ASSERT_IMPLIES(a_err_in_range, clk_i, rst_ni, 1'b1,
                      error_acc_q < ALR_INC_W'(ALR_FULL_SCALE), "error accumulator out of range")
  `ALR_ASSERT_IMPLIES(a_step_needs_line, clk_i, rst_ni, state_q != B_IDLE, active_q,
                      "pixel emitted without a loaded line")
  `ALR_ASSERT_NEXT(a_main_then_neigh, clk_i, rst_ni, (state_q == B_MAIN) && slot_free,
                   (state_q == B_NEIGH) && out_valid_q && !is_nb_q && !last_q,
                   "main pixel not followed by its neighbour")

endmodule

`default_nettype wire

// ----- hdl/antialiased_line_rasterizer.sv -----
// Top level of the antialiased line rasterizer: stream ports, colour registers.
// Depends on alr_pkg, alr_front, alr_fifo and alr_back.
`timescale 1ns / 1ps
`default_nettype none

// Wu-style antialiased line drawer working in hundredths. An input transfer with
// tuser low loads a line from its two endpoints; one with tuser high, while a line
// is active, advances one step and yields two output transfers, the main pixel and
// its neighbour one further along the minor axis, with the line colour split
// between them. After its transfer a load keeps the input stalled while the front
// end classifies the line and runs a one-bit-per-cycle divider once for shallow
// lines and twice for steep ones (not at all on a vertical or single-point line),
// and then until the queue has room for the line. A step is taken whenever the
// front end is idle and the four-entry queue has room, and the back end turns each
// queued step into its pixel pair by dequeue, main pixel and neighbour pixel,
// taking no new step until both pixels are registered and waiting while the
// result held in the output register is not yet taken. Colour registers sit at
// byte addresses 0, 4 and 8 (red, green, blue) and reset to 100.
module antialiased_line_rasterizer #(
  parameter int COORD_BITS = alr_pkg::ALR_COORD_BITS,
  parameter int FIFO_DEPTH = alr_pkg::ALR_FIFO_DEPTH
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  // start_x, start_y, end_x, end_y from bit 0 up, zero padded to bytes
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]         s_axis_tdata_i,
  // op: low loads a line, high advances one step
  input  logic                                      s_axis_tuser_i,
  input  logic                                      s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // pix_x, pix_y, red, green, blue from bit 0 up, zero padded to bytes
  output logic [((2*COORD_BITS+24+7)/8)*8-1:0]      m_axis_tdata_o,
  // is_neighbour
  output logic                                      m_axis_tuser_o,
  output logic                                      m_axis_tlast_o,
  output logic                                      m_axis_tvalid_o,
  input  logic                                      m_axis_tready_i,
  input  logic                                      psel_i,
  input  logic                                      penable_i,
  input  logic                                      pwrite_i,
  input  logic [alr_pkg::ALR_PADDR_W-1:0]           paddr_i,
  input  logic [31:0]                               pwdata_i,
  output logic [31:0]                               prdata_o,
  output logic                                      pready_o
);

  import alr_pkg::*;

  localparam int ENTRY_W    = ALR_ENTRY_FIXED_W + 3 * COORD_BITS;
  localparam int OUT_DATA_W = ((2 * COORD_BITS + 24 + 7) / 8) * 8;

  alr_colour_t      colour_q;
  logic             cfg_write;
  logic [1:0]       reg_sel;

  alr_fifo_status_t fifo_status;
  logic             push, pop;
  logic [ENTRY_W-1:0] push_entry, head_entry;

  logic [COORD_BITS-1:0] pix_x, pix_y;
  logic [7:0]            red, green, blue;

  // Configuration registers.
  assign pready_o  = 1'b1;
  assign cfg_write = psel_i && penable_i && pwrite_i && pready_o;
  assign reg_sel   = paddr_i[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_q.red   <= ALR_COLOUR_RESET;
      colour_q.green <= ALR_COLOUR_RESET;
      colour_q.blue  <= ALR_COLOUR_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        ALR_REG_RED:   colour_q.red   <= pwdata_i[7:0];
        ALR_REG_GREEN: colour_q.green <= pwdata_i[7:0];
        ALR_REG_BLUE:  colour_q.blue  <= pwdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ALR_REG_RED:   prdata_o = 32'(colour_q.red);
      ALR_REG_GREEN: prdata_o = 32'(colour_q.green);
      ALR_REG_BLUE:  prdata_o = 32'(colour_q.blue);
      default:       prdata_o = '0;
    endcase
  end

  alr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .op_i         (s_axis_tuser_i),
    .start_x_i    (s_axis_tdata_i[COORD_BITS-1:0]),
    .start_y_i    (s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS]),
    .end_x_i      (s_axis_tdata_i[3*COORD_BITS-1:2*COORD_BITS]),
    .end_y_i      (s_axis_tdata_i[4*COORD_BITS-1:3*COORD_BITS]),
    .fifo_status_i(fifo_status),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  alr_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .pop_i   (pop),
    .data_o  (head_entry),
    .status_o(fifo_status)
  );

  alr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_status_i (fifo_status),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .colour_i      (colour_q),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .pix_x_o       (pix_x),
    .pix_y_o       (pix_y),
    .red_o         (red),
    .green_o       (green),
    .blue_o        (blue),
    .is_neighbour_o(m_axis_tuser_o),
    .last_o        (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OUT_DATA_W'({blue, green, red, pix_y, pix_x});

endmodule

`default_nettype wire

// ----- tb/tb_antialiased_line_rasterizer.sv -----
// Self-checking testbench for the antialiased line rasterizer: directed and random
// line loads and steps, with the expected pixel pairs predicted in a scoreboard class.
// Depends on alr_pkg and the antialiased_line_rasterizer RTL.
`timescale 1ns / 1ps

module tb_antialiased_line_rasterizer;
  import alr_pkg::*;

  localparam int DATA_W        = 48;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int CHUNK_ITEMS   = 175;
  localparam int HOLD_CYCLES   = 400;

  localparam int MID_NONE  = 0;
  localparam int MID_HOLD  = 1;
  localparam int MID_PAUSE = 2;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        nb;
    logic        lst;
  } pixel_t;

  // Tracks the line state of the block and the pixels it still owes.
  class line_pixel_scoreboard;
    pixel_t pending_pixels[$];
    logic [7:0] colour[3];
    logic signed [11:0] major_pos, major_end, minor_pos;
    logic [6:0] err_acc, err_inc;
    logic [1:0] minor_dir;
    bit y_major, active;
    int errors, loads, steps, checked;

    function new();
      colour = '{ALR_COLOUR_RESET, ALR_COLOUR_RESET, ALR_COLOUR_RESET};
      major_pos = '0;
      major_end = '0;
      minor_pos = '0;
      err_acc = '0;
      err_inc = '0;
      minor_dir = ALR_DIR_NONE;
      y_major = 1'b0;
      active = 1'b0;
    endfunction

    function void set_colour(logic [1:0] idx, logic [7:0] val);
      colour[idx] = val;
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    function void queue_pixel(logic [11:0] major, logic [11:0] minor, int w, bit nb, bit lst);
      pixel_t p;
      p.x = y_major ? minor : major;
      p.y = y_major ? major : minor;
      p.red = 8'(w * colour[ALR_REG_RED] / 255);
      p.green = 8'(w * colour[ALR_REG_GREEN] / 255);
      p.blue = 8'(w * colour[ALR_REG_BLUE] / 255);
      p.nb = nb;
      p.lst = lst;
      pending_pixels.push_back(p);
    endfunction

    // Returns 1 when the transfer loads a line or yields a pixel pair.
    function bit predict_pixels(logic op, logic [DATA_W-1:0] word);
      int ax, ay, bx, by, dx, dy, slope, amaj, amin, bmaj, bmin, t, e;
      logic [7:0] acc_sum;
      bit lst;
      if (op == ALR_OP_LOAD) begin
        ax = $signed(word[11:0]);
        ay = $signed(word[23:12]);
        bx = $signed(word[35:24]);
        by = $signed(word[47:36]);
        dx = (bx > ax) ? bx - ax : ax - bx;
        dy = (by > ay) ? by - ay : ay - by;
        slope = 100;
        if (dx != 0) slope = 100 * dy / dx;
        if (slope < 100) begin
          y_major = 1'b0;
          err_inc = 7'(slope);
          amaj = ax; amin = ay; bmaj = bx; bmin = by;
        end else begin
          y_major = 1'b1;
          err_inc = 7'(10000 / slope);
          amaj = ay; amin = ax; bmaj = by; bmin = bx;
        end
        if (amaj > bmaj) begin
          t = amaj; amaj = bmaj; bmaj = t;
          t = amin; amin = bmin; bmin = t;
        end
        minor_dir = (bmin > amin) ? ALR_DIR_POS : ((bmin < amin) ? ALR_DIR_NEG : ALR_DIR_NONE);
        major_pos = 12'(amaj);
        major_end = 12'(bmaj);
        minor_pos = 12'(amin);
        err_acc = '0;
        active = 1'b1;
        loads++;
        return 1'b1;
      end
      if (!active) return 1'b0;
      steps++;
      e = err_acc * 255 / 100;
      lst = (major_pos >= major_end);
      queue_pixel(major_pos, minor_pos, 255 - e, 1'b0, 1'b0);
      queue_pixel(major_pos, minor_pos + 12'sd1, e, 1'b1, lst);
      acc_sum = {1'b0, err_acc} + {1'b0, err_inc};
      if (acc_sum >= 8'd100) begin
        minor_pos = minor_pos + {{10{minor_dir[1]}}, minor_dir};
        acc_sum = acc_sum - 8'd100;
      end
      err_acc = acc_sum[6:0];
      if (lst) active = 1'b0;
      else major_pos = major_pos + 12'sd1;
      return 1'b1;
    endfunction

    task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      if (errors < 40)
        $display("[%0t] mismatch on %s at pixel %0d: got %0h, wanted %0h",
                 $time, field, checked, got, want);
      errors++;
    endtask

    task check_pixel(logic [DATA_W-1:0] word, logic nb, logic lst);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel with nothing pending", word[31:0], 32'd0);
        return;
      end
      want = pending_pixels.pop_front();
      checked++;
      if (word[11:0] !== want.x) report_mismatch("pix_x", word[11:0], want.x);
      if (word[23:12] !== want.y) report_mismatch("pix_y", word[23:12], want.y);
      if (word[31:24] !== want.red) report_mismatch("red", word[31:24], want.red);
      if (word[39:32] !== want.green) report_mismatch("green", word[39:32], want.green);
      if (word[47:40] !== want.blue) report_mismatch("blue", word[47:40], want.blue);
      if (nb !== want.nb) report_mismatch("is_neighbour", nb, want.nb);
      if (lst !== want.lst) report_mismatch("last", lst, want.lst);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DATA_W-1:0] m_tdata;
  logic m_tuser, m_tlast, m_tvalid;
  logic m_tready = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ALR_PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  line_pixel_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_done = 0;
  int colour_writes = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_go = 1'b0;
  bit hold_taken = 1'b0;

  antialiased_line_rasterizer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped by the cycle limit after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Output side: check each pixel transfer, then pick the next tready.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
      sb.check_pixel(m_tdata, m_tuser, m_tlast);
    if (hold_go && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [DATA_W-1:0] pack_line(int sx, int sy, int ex, int ey);
    return {12'(ey), 12'(ex), 12'(sy), 12'(sx)};
  endfunction

  // Leaves tvalid high after the transfer or drops it for idle; the caller sends or drains.
  task automatic send_item(logic op, logic [DATA_W-1:0] word);
    s_tuser <= op;
    s_tdata <= word;
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (s_tready !== 1'b1);
    if (sb.predict_pixels(op, word)) items_done++;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic send_step();
    send_item(ALR_OP_STEP, {16'($urandom()), $urandom()});
  endtask

  task automatic drain(int settle);
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  // Leaves the port selected after the access; back-to-back writes go straight to setup.
  task automatic apb_write(logic [1:0] idx, logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.set_colour(idx, val);
    colour_writes++;
  endtask

  task automatic set_colours(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    apb_write(ALR_REG_RED, r);
    apb_write(ALR_REG_GREEN, g);
    apb_write(ALR_REG_BLUE, b);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Mostly short well-formed lines, some cut short or overrun, some noise.
  task automatic random_run(int count, int mid_action);
    int goal, half, r, len, ddx, ddy, k, sx, sy, ex, ey, n;
    bit mid_done;
    goal = items_done + count;
    half = items_done + count / 2;
    mid_done = 1'b0;
    while (items_done < goal) begin
      if (!mid_done && items_done >= half) begin
        mid_done = 1'b1;
        if (mid_action == MID_HOLD) hold_go = 1'b1;
        else if (mid_action == MID_PAUSE) drain(0);
      end
      r = $urandom_range(99);
      if (r < 80) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(160, 13) : $urandom_range(12);
        ddx = $urandom_range(len);
        ddy = len;
        if ($urandom_range(1)) begin
          k = ddx; ddx = ddy; ddy = k;
        end
        if ($urandom_range(1)) ddx = -ddx;
        if ($urandom_range(1)) ddy = -ddy;
        sx = int'($urandom_range(4095)) - 2048;
        sy = int'($urandom_range(4095)) - 2048;
        ex = sx + ddx;
        if (ex > 2047 || ex < -2048) ex = sx - ddx;
        ey = sy + ddy;
        if (ey > 2047 || ey < -2048) ey = sy - ddy;
        n = len + 1;
        if (r >= 70) n = $urandom_range(len);
        else if ($urandom_range(3) == 0) n += $urandom_range(1, 2);
        send_item(ALR_OP_LOAD, pack_line(sx, sy, ex, ey));
        repeat (n) send_step();
      end else if (r < 90) begin
        send_item(ALR_OP_LOAD, {16'($urandom()), $urandom()});
        repeat ($urandom_range(3)) send_step();
      end else begin
        repeat ($urandom_range(1, 3)) send_step();
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset colour.
    send_step();
    send_item(ALR_OP_LOAD, pack_line(5, 5, 5, 5));
    repeat (2) send_step();
    send_item(ALR_OP_LOAD, pack_line(0, 0, 10, 3));
    repeat (4) send_step();
    // Diagonal across the whole range, replaced before it ends.
    send_item(ALR_OP_LOAD, pack_line(-2048, -2048, 2047, 2047));
    repeat (2) send_step();
    // Vertical line on the right edge: the neighbour x wraps around.
    send_item(ALR_OP_LOAD, pack_line(2047, -3, 2047, 0));
    repeat (4) send_step();
    send_item(ALR_OP_LOAD, pack_line(3, -2, 0, 0));
    repeat (4) send_step();
    send_item(ALR_OP_LOAD, pack_line(3, 2047, 0, 2040));
    repeat (2) send_step();
    send_item(ALR_OP_LOAD, pack_line(-2048, 2047, 2047, 2046));
    send_step();

    for (int chunk = 0; chunk < 6; chunk++) begin
      drain(SETTLE_CYCLES);
      send_idle_pct = (chunk < 2) ? 9 : ((chunk < 4) ? 85 : 0);
      recv_idle_pct = (chunk < 2) ? 85 : ((chunk < 4) ? 9 : 0);
      case (chunk)
        0: set_colours(8'd255, 8'd255, 8'd255);
        1: set_colours(8'd0, 8'd0, 8'd0);
        2: set_colours(8'd255, 8'd0, 8'd128);
        4: set_colours(8'd1, 8'd254, 8'd77);
        default: set_colours(8'($urandom()), 8'($urandom()), 8'($urandom()));
      endcase
      random_run(CHUNK_ITEMS, (chunk == 0) ? MID_HOLD : ((chunk == 4) ? MID_PAUSE : MID_NONE));
    end
    drain(SETTLE_CYCLES);

    $display("Lines loaded: %0d, steps drawn: %0d, pixels checked: %0d, mismatches: %0d",
             sb.loads, sb.steps, sb.checked, sb.errors);
    $display("Reset colour plus %0d register writes, three idle regimes, one long output stall",
             colour_writes);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/alr_pkg.sv
hdl/alr_div.sv
hdl/alr_front.sv
hdl/alr_fifo.sv
hdl/alr_back.sv
hdl/antialiased_line_rasterizer.sv
tb/tb_antialiased_line_rasterizer.sv
